// ===== rtl/traffic_light_controller_core_assert.svh =====
// Assertion macros shared by the traffic light controller checkers.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef TRAFFIC_LIGHT_CONTROLLER_CORE_ASSERT_SVH
`define TRAFFIC_LIGHT_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TLC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tlc_pkg.sv =====
// Shared types and constants for the traffic light controller.
// No dependencies; imported by the debounce, output buffer and core modules.
package tlc_pkg;

  // Configuration port shape
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_REGS   = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RED        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_YELLOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_BLNK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd6;

  // Register values after reset, in ticks
  localparam logic [CFG_DATA_W-1:0] RST_RED        = 16'd5000;
  localparam logic [CFG_DATA_W-1:0] RST_RED_YELLOW = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] RST_GREEN      = 16'd4000;
  localparam logic [CFG_DATA_W-1:0] RST_GREEN_BLNK = 16'd3000;
  localparam logic [CFG_DATA_W-1:0] RST_YELLOW     = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] RST_BLINK_HALF = 16'd500;
  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE   = 16'd50;

  // Lamp vector: bit 0 red, bit 1 yellow, bit 2 green
  typedef logic [2:0] lamps_t;
  localparam lamps_t LAMP_OFF = 3'b000;
  localparam lamps_t LAMP_R   = 3'b001;
  localparam lamps_t LAMP_Y   = 3'b010;
  localparam lamps_t LAMP_G   = 3'b100;
  localparam lamps_t LAMP_RY  = 3'b011;

  // Normal-mode phase sequencer
  typedef enum logic [4:0] {
    PH_RED         = 5'b00001,
    PH_RED_YELLOW  = 5'b00010,
    PH_GREEN       = 5'b00100,
    PH_GREEN_BLINK = 5'b01000,
    PH_YELLOW      = 5'b10000
  } phase_t;

  // Button debounce states
  typedef enum logic [3:0] {
    BTN_RELEASED     = 4'b0001,
    BTN_PEND_PRESS   = 4'b0010,
    BTN_PRESSED      = 4'b0100,
    BTN_PEND_RELEASE = 4'b1000
  } btn_state_t;

  // One result transaction
  typedef struct packed {
    logic red_on;
    logic yellow_on;
    logic green_on;
    logic blinking_mode;
  } result_t;

endpackage

// ===== rtl/tlc_debounce.sv =====
// Button debouncer: a level change must hold for the debounce time.
// Depends on tlc_pkg; reports an accepted press in the same tick.
module tlc_debounce import tlc_pkg::*; #(
  parameter int TIME_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tick,
  input  logic                  btn_level,
  input  logic [TIME_WIDTH-1:0] db_time,
  output logic                  press
);

  localparam logic [TIME_WIDTH-1:0] CNT_MAX = {TIME_WIDTH{1'b1}};

  btn_state_t            state_r, state_nxt;
  logic [TIME_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [TIME_WIDTH-1:0] cnt_inc;
  logic                  press_c;

  // Saturating count of ticks at the new level
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;

  // Next state; a bounce back cancels a pending change
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    press_c   = 1'b0;
    unique case (state_r)
      BTN_RELEASED: begin
        if (!btn_level) begin
          state_nxt = BTN_PEND_PRESS;
          cnt_nxt   = '0;
        end
      end
      BTN_PEND_PRESS: begin
        if (btn_level) begin
          state_nxt = BTN_RELEASED;
        end else begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= db_time) begin
            state_nxt = BTN_PRESSED;
            press_c   = 1'b1;
          end
        end
      end
      BTN_PRESSED: begin
        if (btn_level) begin
          state_nxt = BTN_PEND_RELEASE;
          cnt_nxt   = '0;
        end
      end
      BTN_PEND_RELEASE: begin
        if (!btn_level) begin
          state_nxt = BTN_PRESSED;
        end else begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= db_time) begin
            state_nxt = BTN_RELEASED;
          end
        end
      end
      default: begin
        state_nxt = BTN_RELEASED;
      end
    endcase
  end

  assign press = tick && press_c;

  // Advance only on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BTN_RELEASED;
      cnt_r   <= '0;
    end else if (tick) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/tlc_out_buf.sv =====
// Two-entry output buffer (head plus skid register) for result transactions.
// Depends on tlc_pkg; push_ready is registered and independent of pop_ready.
module tlc_out_buf import tlc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  result_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output result_t pop_data
);

  result_t head_r, head_nxt;
  result_t skid_r, skid_nxt;
  logic    head_vld_r, head_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  logic    push, pop;

  assign push_ready = !skid_vld_r;
  assign push       = push_valid && push_ready;
  assign pop        = head_vld_r && pop_ready;
  assign pop_valid  = head_vld_r;
  assign pop_data   = head_r;

  // Keep order: the skid entry always moves into the head before a new one
  always_comb begin
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (pop) begin
      if (skid_vld_r) begin
        head_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        head_vld_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!head_vld_nxt) begin
        head_nxt     = push_data;
        head_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== rtl/traffic_light_controller_core.sv =====
// Traffic light controller. Each input transaction is one millisecond tick
// with the raw button level; each produces exactly one result transaction
// with the lamp levels and the mode after that tick. One tick is accepted
// every clock cycle while in_ready is high: the timing and debounce state
// updates on acceptance; the result is registered in the output buffer.
// A two-entry output buffer keeps in_ready high while one result waits, so
// the rate is set only by how fast results are taken. Phase lengths are
// counted in ticks, not clock cycles; write the registers only while idle.
module traffic_light_controller_core import tlc_pkg::*; #(
  parameter int TIME_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_button_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_red_on,
  output logic                  out_yellow_on,
  output logic                  out_green_on,
  output logic                  out_blinking_mode
);

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
  localparam logic [TIME_WIDTH-1:0] TIME_ONE = TIME_WIDTH'(1);

  logic [TIME_WIDTH-1:0] red_t_r, red_yel_t_r, green_t_r, green_blk_t_r;
  logic [TIME_WIDTH-1:0] yellow_t_r, half_t_r, db_t_r;

  logic                  mode_r, mode_nxt;
  phase_t                phase_r, phase_nxt;
  logic [TIME_WIDTH-1:0] time_left_r, time_left_nxt;
  logic                  blink_r, blink_nxt;
  logic [TIME_WIDTH-1:0] elapsed_r, elapsed_nxt;
  lamps_t                lamps_r, lamps_nxt;

  logic                  accept;
  logic                  press;
  logic [TIME_WIDTH-1:0] half_len;
  logic [TIME_WIDTH:0]   elapsed_sum;
  logic [TIME_WIDTH-1:0] elapsed_sat;
  result_t               res;

  assign accept = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_t_r       <= TIME_WIDTH'(RST_RED);
      red_yel_t_r   <= TIME_WIDTH'(RST_RED_YELLOW);
      green_t_r     <= TIME_WIDTH'(RST_GREEN);
      green_blk_t_r <= TIME_WIDTH'(RST_GREEN_BLNK);
      yellow_t_r    <= TIME_WIDTH'(RST_YELLOW);
      half_t_r      <= TIME_WIDTH'(RST_BLINK_HALF);
      db_t_r        <= TIME_WIDTH'(RST_DEBOUNCE);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RED:        red_t_r       <= TIME_WIDTH'(cfg_wdata);
        REG_RED_YELLOW: red_yel_t_r   <= TIME_WIDTH'(cfg_wdata);
        REG_GREEN:      green_t_r     <= TIME_WIDTH'(cfg_wdata);
        REG_GREEN_BLNK: green_blk_t_r <= TIME_WIDTH'(cfg_wdata);
        REG_YELLOW:     yellow_t_r    <= TIME_WIDTH'(cfg_wdata);
        REG_BLINK_HALF: half_t_r      <= TIME_WIDTH'(cfg_wdata);
        REG_DEBOUNCE:   db_t_r        <= TIME_WIDTH'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  tlc_debounce #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_debounce (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (accept),
    .btn_level (in_button_level),
    .db_time   (db_t_r),
    .press     (press)
  );

  // Blink half period, zero acting as one tick, and the saturating total
  assign half_len    = (half_t_r == '0) ? TIME_ONE : half_t_r;
  assign elapsed_sum = {1'b0, elapsed_r} + {1'b0, half_len};
  assign elapsed_sat = elapsed_sum[TIME_WIDTH] ? TIME_MAX : elapsed_sum[TIME_WIDTH-1:0];

  // Per-tick update: mode toggle, phase end, or count down
  always_comb begin
    mode_nxt      = mode_r;
    phase_nxt     = phase_r;
    time_left_nxt = time_left_r;
    blink_nxt     = blink_r;
    elapsed_nxt   = elapsed_r;
    lamps_nxt     = lamps_r;
    if (press) begin
      if (!mode_r) begin
        mode_nxt      = 1'b1;
        lamps_nxt     = LAMP_Y;
        blink_nxt     = 1'b0;
        time_left_nxt = half_t_r;
      end else begin
        mode_nxt      = 1'b0;
        phase_nxt     = PH_RED;
        lamps_nxt     = LAMP_R;
        time_left_nxt = red_t_r;
      end
    end else if (time_left_r <= TIME_ONE) begin
      if (mode_r) begin
        lamps_nxt     = blink_r ? LAMP_Y : LAMP_OFF;
        blink_nxt     = !blink_r;
        time_left_nxt = half_t_r;
      end else begin
        unique case (phase_r)
          PH_RED: begin
            phase_nxt     = PH_RED_YELLOW;
            lamps_nxt     = LAMP_RY;
            time_left_nxt = red_yel_t_r;
          end
          PH_RED_YELLOW: begin
            phase_nxt     = PH_GREEN;
            lamps_nxt     = LAMP_G;
            time_left_nxt = green_t_r;
          end
          PH_GREEN: begin
            // Blinking green opens with a lit half period
            phase_nxt     = PH_GREEN_BLINK;
            lamps_nxt     = LAMP_G;
            blink_nxt     = 1'b0;
            time_left_nxt = half_t_r;
            elapsed_nxt   = half_len;
          end
          PH_GREEN_BLINK: begin
            if (elapsed_r >= green_blk_t_r) begin
              phase_nxt     = PH_YELLOW;
              lamps_nxt     = LAMP_Y;
              time_left_nxt = yellow_t_r;
            end else begin
              lamps_nxt     = blink_r ? LAMP_G : LAMP_OFF;
              blink_nxt     = !blink_r;
              time_left_nxt = half_t_r;
              elapsed_nxt   = elapsed_sat;
            end
          end
          default: begin
            phase_nxt     = PH_RED;
            lamps_nxt     = LAMP_R;
            time_left_nxt = red_t_r;
          end
        endcase
      end
    end else begin
      time_left_nxt = time_left_r - TIME_ONE;
    end
  end

  // Sequencer state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      phase_r     <= PH_RED;
      time_left_r <= TIME_WIDTH'(RST_RED);
      blink_r     <= 1'b1;
      elapsed_r   <= '0;
      lamps_r     <= LAMP_R;
    end else if (accept) begin
      mode_r      <= mode_nxt;
      phase_r     <= phase_nxt;
      time_left_r <= time_left_nxt;
      blink_r     <= blink_nxt;
      elapsed_r   <= elapsed_nxt;
      lamps_r     <= lamps_nxt;
    end
  end

  // Result of this tick
  assign res.red_on        = lamps_nxt[0];
  assign res.yellow_on     = lamps_nxt[1];
  assign res.green_on      = lamps_nxt[2];
  assign res.blinking_mode = mode_nxt;

  result_t out_data;

  tlc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (res),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_data)
  );

  assign out_red_on        = out_data.red_on;
  assign out_yellow_on     = out_data.yellow_on;
  assign out_green_on      = out_data.green_on;
  assign out_blinking_mode = out_data.blinking_mode;

endmodule

// ===== rtl/tlc_checker.sv =====
// Port-level checker for the traffic light controller, bound to the top level.
// Depends on traffic_light_controller_core_assert.svh for the assertion macros.
`include "traffic_light_controller_core_assert.svh"

module tlc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_red_on,
  input logic out_yellow_on,
  input logic out_green_on,
  input logic out_blinking_mode
);

  // A stalled result transaction holds its payload
  `TLC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_red_on) && $stable(out_yellow_on) && $stable(out_green_on) && $stable(out_blinking_mode), "result changed while stalled")

  // Every accepted tick leaves a result pending
  `TLC_ASSERT_NXT(a_tick_result, in_valid && in_ready, out_valid, "accepted tick produced no result")

  // Normal mode never shows green together with red or yellow
  `TLC_ASSERT_IMP(a_green_alone, out_valid && !out_blinking_mode, !(out_green_on && (out_red_on || out_yellow_on)), "green shown with another lamp")

  // Blinking mode drives the yellow lamp only
  `TLC_ASSERT_IMP(a_blink_yellow, out_valid && out_blinking_mode, !out_red_on && !out_green_on, "red or green lit in blinking mode")

endmodule

bind traffic_light_controller_core tlc_checker u_tlc_checker (.*);
